@@ design/hbds_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package hbds_pkg;

    localparam int unsigned DUTY_W  = 13;
    localparam int unsigned TICK_W  = 16;
    localparam int unsigned BTIME_W = 17;
    localparam int unsigned DUTY_ONE_W = 17;

    typedef enum logic [2:0] {
        OP_TICK  = 3'd0,
        OP_FWD   = 3'd1,
        OP_REV   = 3'd2,
        OP_DUTY  = 3'd3,
        OP_BRAKE = 3'd4,
        OP_OFF   = 3'd5
    } op_t;

    typedef enum logic [2:0] {
        ST_OFF = 3'd0,
        ST_FWD = 3'd1,
        ST_REV = 3'd2,
        ST_BRK = 3'd3,
        ST_TRS = 3'd4
    } bridge_state_t;

    typedef enum logic {
        MODE_DRIVE_BRAKE = 1'b0,
        MODE_DRIVE_COAST = 1'b1
    } drive_mode_t;

    // Result beat, lowest field in the lowest bits.
    typedef struct packed {
        logic                ev_initialized;
        logic                ev_brake_done;
        logic                ev_brake_started;
        logic                ev_pwm_changed;
        logic [2:0]          bridge_state;
        logic                pwm_running;
        logic [DUTY_W-1:0]   duty_b;
        logic [DUTY_W-1:0]   duty_a;
        logic                status;
    } result_t;

endpackage

`default_nettype wire

@@ design/h_bridge_drive_sequencer.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A result beat goes to the result register, or to the skid register while the
// output stalls. Throughput: one command beat per cycle while the skid register
// is empty; the state update is a single pass from the command and the bridge
// state registers to the result register. This two-entry output stage lets a
// beat in while the previous result waits. Synchronous active-low reset puts
// the bridge in the power-up brake, both channels full on, timer at TR_TICKS.

module h_bridge_drive_sequencer
    import hbds_pkg::*;
#(
    parameter int unsigned TR_TICKS = 10,
    parameter int unsigned DUTY_ONE = 4096
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic        cfg_data,        // drive_mode

    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [2:0] operation, [15:3] duty, [32:16] brake_time, [39:33] zero
    input  wire logic [39:0] s_tdata,

    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [0] status, [13:1] duty_a, [26:14] duty_b, [27] pwm_running,
    // [30:28] bridge_state, [31] ev_pwm_changed, [32] ev_brake_started,
    // [33] ev_brake_done, [34] ev_initialized, [39:35] zero
    output logic [39:0]      m_tdata
);

    localparam logic [DUTY_ONE_W-1:0] DUTY_ONE_FULL = DUTY_ONE_W'(DUTY_ONE);
    localparam logic [DUTY_W-1:0]     DUTY_ONE_LO   = DUTY_ONE_FULL[DUTY_W-1:0];
    localparam logic [TICK_W-1:0]     TR_MIN        = TICK_W'(TR_TICKS);

    drive_mode_t         drive_mode_reg;
    bridge_state_t       state_reg, state_next;
    logic [DUTY_W-1:0]   held_reg, held_next;
    logic [DUTY_W-1:0]   cha_reg, cha_next;
    logic [DUTY_W-1:0]   chb_reg, chb_next;
    logic                pwm_reg, pwm_next;
    logic [TICK_W-1:0]   ticks_reg, ticks_next;
    logic                armed_reg, armed_next;
    logic                init_reg, init_next;

    result_t             out_reg, skid_reg, res;
    logic                out_valid_reg, skid_valid_reg;

    op_t                 op;
    logic [DUTY_W-1:0]   d;
    logic [BTIME_W-1:0]  bt;
    logic                duty_big;
    logic                do_off;
    logic                accept;
    logic                out_free;
    bridge_state_t       dir;

    assign op       = op_t'(s_tdata[2:0]);
    assign d        = s_tdata[15:3];
    assign bt       = s_tdata[32:16];
    assign duty_big = {4'b0, d} > DUTY_ONE_FULL;

    assign cfg_ready = 1'b1;
    assign s_tready  = !skid_valid_reg;
    assign accept    = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {5'b0, out_reg};
    assign dir       = (op == OP_FWD) ? ST_FWD : ST_REV;

    always_comb begin
        state_next = state_reg;
        held_next  = held_reg;
        cha_next   = cha_reg;
        chb_next   = chb_reg;
        pwm_next   = pwm_reg;
        ticks_next = ticks_reg;
        armed_next = armed_reg;
        init_next  = init_reg;
        do_off     = 1'b0;
        res        = '0;

        case (op)
            OP_TICK: begin
                if (armed_reg) begin
                    if (ticks_reg <= TICK_W'(1)) begin
                        ticks_next = '0;
                        armed_next = 1'b0;
                        do_off     = 1'b1;
                    end else begin
                        ticks_next = ticks_reg - TICK_W'(1);
                    end
                end
            end
            OP_FWD, OP_REV: begin
                if (duty_big) begin
                    res.status = 1'b1;
                end else if (state_reg == dir && held_reg == d) begin
                    res.status = 1'b0;
                end else if (state_reg inside {ST_BRK, ST_TRS}) begin
                    res.status = 1'b1;
                end else begin
                    held_next = d;
                    pwm_next  = 1'b1;
                    if (dir == ST_FWD) begin
                        if (drive_mode_reg == MODE_DRIVE_BRAKE) begin
                            cha_next = DUTY_ONE_LO;
                            chb_next = d;
                        end else begin
                            cha_next = d;
                            chb_next = '0;
                        end
                    end else begin
                        if (drive_mode_reg == MODE_DRIVE_BRAKE) begin
                            cha_next = d;
                            chb_next = DUTY_ONE_LO;
                        end else begin
                            cha_next = '0;
                            chb_next = d;
                        end
                    end
                    state_next         = dir;
                    res.ev_pwm_changed = 1'b1;
                end
            end
            OP_DUTY: begin
                if (duty_big) begin
                    res.status = 1'b1;
                end else if (state_reg == ST_FWD) begin
                    if (drive_mode_reg == MODE_DRIVE_BRAKE) chb_next = d;
                    else cha_next = d;
                    held_next = d;
                end else if (state_reg == ST_REV) begin
                    if (drive_mode_reg == MODE_DRIVE_BRAKE) cha_next = d;
                    else chb_next = d;
                    held_next = d;
                end else begin
                    res.status = 1'b1;
                end
            end
            OP_BRAKE: begin
                if (state_reg inside {ST_BRK, ST_TRS}) begin
                    res.status = 1'b1;
                end else begin
                    cha_next             = DUTY_ONE_LO;
                    chb_next             = DUTY_ONE_LO;
                    pwm_next             = 1'b1;
                    state_next           = ST_BRK;
                    res.ev_brake_started = 1'b1;
                    if (!bt[BTIME_W-1]) begin
                        ticks_next = (bt[TICK_W-1:0] < TR_MIN) ? TR_MIN : bt[TICK_W-1:0];
                        armed_next = 1'b1;
                    end
                end
            end
            OP_OFF: begin
                if (state_reg == ST_OFF) begin
                    res.status = 1'b0;
                end else if (state_reg inside {ST_BRK, ST_TRS}) begin
                    res.status = 1'b1;
                end else begin
                    do_off = 1'b1;
                end
            end
            default: begin
                res.status = 1'b1;
            end
        endcase

        if (do_off) begin
            cha_next           = '0;
            chb_next           = '0;
            pwm_next           = 1'b0;
            state_next         = ST_OFF;
            res.ev_pwm_changed = 1'b1;
            if (state_reg == ST_BRK) begin
                res.ev_brake_done = 1'b1;
            end else if (init_reg) begin
                res.ev_initialized = 1'b1;
                init_next          = 1'b0;
            end
        end

        res.duty_a       = cha_next;
        res.duty_b       = chb_next;
        res.pwm_running  = pwm_next;
        res.bridge_state = state_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            drive_mode_reg <= MODE_DRIVE_BRAKE;
            state_reg      <= ST_TRS;
            held_reg       <= '0;
            cha_reg        <= DUTY_ONE_LO;
            chb_reg        <= DUTY_ONE_LO;
            pwm_reg        <= 1'b1;
            ticks_reg      <= TR_MIN;
            armed_reg      <= 1'b1;
            init_reg       <= 1'b1;
        end else begin
            if (cfg_valid && cfg_ready) begin
                drive_mode_reg <= drive_mode_t'(cfg_data);
            end
            if (accept) begin
                state_reg <= state_next;
                held_reg  <= held_next;
                cha_reg   <= cha_next;
                chb_reg   <= chb_next;
                pwm_reg   <= pwm_next;
                ticks_reg <= ticks_next;
                armed_reg <= armed_next;
                init_reg  <= init_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg  <= skid_valid_reg || accept;
            skid_valid_reg <= 1'b0;
        end else if (accept) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_free) begin
            if (skid_valid_reg) begin
                out_reg <= skid_reg;
            end else if (accept) begin
                out_reg <= res;
            end
        end else if (accept) begin
            skid_reg <= res;
        end
    end

endmodule

`default_nettype wire
